// ----- hw/rtl/rafc_pkg.sv -----
// Shared types, codes and tables for the radiation alarm and fault controller.
// No dependencies; used by rafc_step and radiation_alarm_fault_controller.
package rafc_pkg;

	typedef enum logic [3:0] {
		MODE_NORMAL   = 4'd0,
		MODE_ALARM    = 4'd1,
		MODE_OVERRUN  = 4'd2,
		MODE_OVERLOAD = 4'd3,
		MODE_ACK_AL   = 4'd4,
		MODE_ACK_OR   = 4'd5,
		MODE_ACK_OL   = 4'd6,
		MODE_HV       = 4'd7,
		MODE_DTC      = 4'd8
	} mode_t;

	// status flag masks
	localparam logic [6:0] ST_ALARM    = 7'h01;
	localparam logic [6:0] ST_OVERLOAD = 7'h02;
	localparam logic [6:0] ST_OVERRUN  = 7'h04;
	localparam logic [6:0] ST_ACK      = 7'h08;
	localparam logic [6:0] ST_RESET    = 7'h10;
	localparam logic [6:0] ST_HV       = 7'h20;
	localparam logic [6:0] ST_DTC      = 7'h40;

	// indicator patterns: bit0 red, 1 green, 2 yellow, 3 buzzer, 4 relay
	localparam logic [4:0] IND_NORMAL = 5'h12;
	localparam logic [4:0] IND_ACTIVE = 5'h09;
	localparam logic [4:0] IND_ACKED  = 5'h01;
	localparam logic [4:0] IND_FAULT  = 5'h04;

	localparam int unsigned CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_LEVEL    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OVERRUN_LEVEL  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OVERLOAD_LEVEL = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HV_LOW_LIMIT   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HV_HIGH_LIMIT  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_MODE      = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HV_HOLDOFF_MS  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_ACK_MS    = 4'd7;

	localparam logic [7:0] MISS_LIMIT = 8'd3;

	typedef struct packed {
		logic [26:0] alarm_level;
		logic [26:0] overrun_level;
		logic [26:0] overload_level;
		logic [14:0] hv_low_limit;
		logic [14:0] hv_high_limit;
		logic        auto_mode;
		logic [15:0] hv_holdoff_ms;
		logic [19:0] auto_ack_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [23:0] dose_mrh_centi;
		logic [14:0] hv_decivolts;
		logic        ack_btn;
		logic        rst_btn;
		logic [7:0]  detector_misses;
		logic        detector_recovered;
	} item_t;

	typedef struct packed {
		mode_t       alarm_mode;
		logic [6:0]  status_flags;
		logic        detector_failed;
		logic        detector_failed_prev;
		logic [31:0] ack_timer_start;
		logic [31:0] hv_timer_start;
		logic        hv_timer_armed;
		logic [4:0]  indicator_pattern;
	} state_t;

	typedef struct packed {
		mode_t      mode;
		logic [6:0] status_bits;
		logic [4:0] indicators;
		logic       mode_changed;
	} result_t;

	function automatic logic [4:0] pattern_of_mode(input mode_t m);
		logic [4:0] p;
		unique case (m)
			MODE_ALARM, MODE_OVERRUN, MODE_OVERLOAD: p = IND_ACTIVE;
			MODE_ACK_AL, MODE_ACK_OR, MODE_ACK_OL:   p = IND_ACKED;
			MODE_HV, MODE_DTC:                       p = IND_FAULT;
			default:                                 p = IND_NORMAL;
		endcase
		return p;
	endfunction

endpackage

// ----- hw/rtl/rafc_step.sv -----
// One evaluation of the alarm mode machine: current state and item in,
// next state and result word out. Pure logic; uses rafc_pkg.
module rafc_step
	import rafc_pkg::*;
(
	input  cfg_t    cfg,
	input  state_t  cur,
	input  item_t   item,
	output state_t  nxt,
	output result_t res
);

	mode_t       m;
	logic [6:0]  f;
	logic        df;
	logic        dfp;
	logic        armed;
	logic [31:0] hv_start;
	logic [31:0] ack_start;
	logic [27:0] rad;
	logic [27:0] lvl_al;
	logic [27:0] lvl_or;
	logic [27:0] lvl_ol;
	logic        hv_out;
	logic        hv_in;
	logic        holdoff_done;
	logic        ack_timeout;

	assign lvl_al = {1'b0, cfg.alarm_level};
	assign lvl_or = {1'b0, cfg.overrun_level};
	assign lvl_ol = {1'b0, cfg.overload_level};

	assign hv_out = (item.hv_decivolts < cfg.hv_low_limit) ||
		(item.hv_decivolts > cfg.hv_high_limit);
	assign hv_in = (item.hv_decivolts > cfg.hv_low_limit) &&
		(item.hv_decivolts < cfg.hv_high_limit);

	// next state
	always_comb begin
		m         = cur.alarm_mode;
		f         = cur.status_flags;
		armed     = cur.hv_timer_armed;
		hv_start  = cur.hv_timer_start;
		ack_start = cur.ack_timer_start;
		dfp       = cur.detector_failed_prev;

		if (!armed) begin
			hv_start = item.now_ms;
			armed    = 1'b1;
		end

		// recovery clears first, misses may set it again
		df = cur.detector_failed;
		if (item.detector_recovered) df = 1'b0;
		if (item.detector_misses >= MISS_LIMIT) df = 1'b1;

		if (df != dfp) begin
			if (df) begin
				m = MODE_DTC;
				f = ST_DTC;
			end else begin
				m        = MODE_NORMAL;
				f        = ST_RESET;
				hv_start = item.now_ms;
				armed    = 1'b1;
			end
			dfp = df;
		end

		// x10 as shift-add, mR/h to uSv/h
		rad = df ? 28'd0 :
			({1'b0, item.dose_mrh_centi, 3'b000} + {3'b000, item.dose_mrh_centi, 1'b0});

		holdoff_done = (item.now_ms - hv_start) > {16'd0, cfg.hv_holdoff_ms};

		if (rad >= lvl_ol && m != MODE_OVERLOAD && m != MODE_ACK_OL && m != MODE_DTC) begin
			m = MODE_OVERLOAD;
			f = (f & ~(ST_ALARM | ST_OVERRUN | ST_RESET | ST_ACK | ST_HV)) | ST_OVERLOAD;
			ack_start = item.now_ms;
		end else if (rad >= lvl_or && m != MODE_OVERRUN && m != MODE_OVERLOAD &&
				m != MODE_ACK_OL && m != MODE_ACK_OR && m != MODE_DTC) begin
			m = MODE_OVERRUN;
			f = (f & ~(ST_ALARM | ST_RESET | ST_ACK | ST_HV)) | ST_OVERRUN;
			ack_start = item.now_ms;
		end else if (rad >= lvl_al && (m == MODE_NORMAL || m == MODE_HV)) begin
			m = MODE_ALARM;
			f = (f & ~(ST_RESET | ST_HV)) | ST_ALARM;
			ack_start = item.now_ms;
		end else if (hv_out && m == MODE_NORMAL && armed && holdoff_done) begin
			m     = MODE_HV;
			f     = (f & ~ST_RESET) | ST_HV;
			armed = 1'b0;
		end

		if (m == MODE_HV && hv_in) begin
			m = MODE_NORMAL;
			f = (f & ~ST_HV) | ST_RESET;
		end

		ack_timeout = cfg.auto_mode &&
			((item.now_ms - ack_start) > {12'd0, cfg.auto_ack_ms});

		if ((m == MODE_ALARM || m == MODE_OVERRUN || m == MODE_OVERLOAD) &&
				(item.ack_btn || ack_timeout)) begin
			unique case (m)
				MODE_ALARM:   m = MODE_ACK_AL;
				MODE_OVERRUN: m = MODE_ACK_OR;
				default:      m = MODE_ACK_OL;
			endcase
			f         = f | ST_ACK;
			ack_start = item.now_ms;
		end

		if (((m == MODE_ACK_OL && rad < lvl_ol) ||
				(m == MODE_ACK_AL && rad < lvl_al) ||
				(m == MODE_ACK_OR && rad < lvl_or)) &&
				(item.rst_btn || cfg.auto_mode)) begin
			m = MODE_NORMAL;
			f = (f & ~(ST_ACK | ST_OVERLOAD | ST_OVERRUN | ST_ALARM | ST_HV)) | ST_RESET;
		end

		nxt.alarm_mode           = m;
		nxt.status_flags         = f;
		nxt.detector_failed      = df;
		nxt.detector_failed_prev = dfp;
		nxt.ack_timer_start      = ack_start;
		nxt.hv_timer_start       = hv_start;
		nxt.hv_timer_armed       = armed;
		nxt.indicator_pattern    = (m != cur.alarm_mode) ?
			pattern_of_mode(m) : cur.indicator_pattern;
	end

	// outputs
	always_comb begin
		res.mode         = nxt.alarm_mode;
		res.status_bits  = nxt.status_flags;
		res.indicators   = nxt.indicator_pattern;
		res.mode_changed = (nxt.alarm_mode != cur.alarm_mode);
	end

endmodule

// ----- hw/rtl/radiation_alarm_fault_controller.sv -----
// Top level of the radiation alarm and fault controller: stream ports,
// register file, input stage, state and result register. Uses rafc_pkg, rafc_step.
//
//  channel   dir  handshake              word
//  s_axis    in   tvalid/tready          one evaluation item (88-bit tdata)
//  m_axis    out  tvalid/tready          one result (24-bit tdata)
//  cfg       in   cfg_valid/cfg_ready    register index + 32-bit data
//
// One item per cycle sustained while m_axis accepts. Each item passes the input
// register, then the evaluation (x10 shift-add, threshold and time compares)
// into the result register together with the state update.
// A stalled m_axis holds the result; the input stage then fills and s_axis
// tready drops. cfg_ready is always high. Reset restores the register
// defaults and the normal mode with green and relay on.
module radiation_alarm_fault_controller
	import rafc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [31:0] now_ms, [55:32] dose_mrh_centi, [70:56] hv_decivolts,
	// [71] ack_btn, [72] rst_btn, [80:73] detector_misses,
	// [81] detector_recovered, [87:82] zero
	input  logic [87:0]          s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [3:0] mode, [10:4] status_bits, [15:11] indicators, [16] mode_changed,
	// [23:17] zero
	output logic [23:0]          m_axis_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	item_t   item_in;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alarm_level    <= '0;
			cfg_q.overrun_level  <= '0;
			cfg_q.overload_level <= '0;
			cfg_q.hv_low_limit   <= '0;
			cfg_q.hv_high_limit  <= 15'd20000;
			cfg_q.auto_mode      <= 1'b0;
			cfg_q.hv_holdoff_ms  <= 16'd5000;
			cfg_q.auto_ack_ms    <= 20'd60000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ALARM_LEVEL:    cfg_q.alarm_level    <= cfg_data[26:0];
				REG_OVERRUN_LEVEL:  cfg_q.overrun_level  <= cfg_data[26:0];
				REG_OVERLOAD_LEVEL: cfg_q.overload_level <= cfg_data[26:0];
				REG_HV_LOW_LIMIT:   cfg_q.hv_low_limit   <= cfg_data[14:0];
				REG_HV_HIGH_LIMIT:  cfg_q.hv_high_limit  <= cfg_data[14:0];
				REG_AUTO_MODE:      cfg_q.auto_mode      <= cfg_data[0];
				REG_HV_HOLDOFF_MS:  cfg_q.hv_holdoff_ms  <= cfg_data[15:0];
				REG_AUTO_ACK_MS:    cfg_q.auto_ack_ms    <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	assign item_in.now_ms             = s_axis_tdata[31:0];
	assign item_in.dose_mrh_centi     = s_axis_tdata[55:32];
	assign item_in.hv_decivolts       = s_axis_tdata[70:56];
	assign item_in.ack_btn            = s_axis_tdata[71];
	assign item_in.rst_btn            = s_axis_tdata[72];
	assign item_in.detector_misses    = s_axis_tdata[80:73];
	assign item_in.detector_recovered = s_axis_tdata[81];

	// the input stage moves on whenever the result register is free or drains
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_in;
		end
	end

	rafc_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.alarm_mode           <= MODE_NORMAL;
			state_q.status_flags         <= '0;
			state_q.detector_failed      <= 1'b0;
			state_q.detector_failed_prev <= 1'b0;
			state_q.ack_timer_start      <= '0;
			state_q.hv_timer_start       <= '0;
			state_q.hv_timer_armed       <= 1'b0;
			state_q.indicator_pattern    <= IND_NORMAL;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, res_q.mode_changed, res_q.indicators,
		res_q.status_bits, res_q.mode};

endmodule

// ----- tb/tb_radiation_alarm_fault_controller.sv -----
// Self-checking bench for radiation_alarm_fault_controller: drives evaluation words,
// predicts mode, status and indicators per word and checks every result word.
// Depends on rafc_pkg and the controller RTL only.
module tb_radiation_alarm_fault_controller;
	timeunit 1ns;
	timeprecision 1ps;
	import rafc_pkg::*;

	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int PHASES         = 9;
	localparam int PHASE_ITEMS    = 200;
	localparam int PRESSURE_PHASE = 2;
	localparam int WRAP_PHASE     = 5;
	localparam int DOSE_MAX       = 16777215;
	localparam int HV_MAX         = 32767;

	localparam int FLAVOR_ORDERED = 0;
	localparam int FLAVOR_ZERO    = 1;
	localparam int FLAVOR_MAX     = 2;
	localparam int FLAVOR_WILD    = 3;

	// index with no register behind it; writes must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd12;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [87:0]          s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [23:0]          m_axis_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	radiation_alarm_fault_controller uut (.*);

	always #5 clk = ~clk;

	// predictor copy of the configuration and controller state
	cfg_t        pcfg;
	mode_t       cur_mode = MODE_NORMAL;
	logic [6:0]  cur_flags = '0;
	logic        det_failed = 1'b0;
	logic        det_failed_prev = 1'b0;
	logic [31:0] ack_start = '0;
	logic [31:0] hv_start = '0;
	logic        hv_armed = 1'b0;
	logic [4:0]  ind_pat = IND_NORMAL;

	item_t       reading_q[$];
	result_t     awaited_results[$];
	item_t       tx_item;
	logic [31:0] cur_now = '0;
	int          errors = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	int          rx_hold_req = 0;
	int          rx_hold_ack = 0;
	int          tx_gap = 0;
	int          rx_gap = 0;
	int          stall_cycles = 0;

	function automatic result_t evaluate_reading(input item_t r);
		result_t     res;
		mode_t       was;
		mode_t       m;
		logic [6:0]  f;
		logic [31:0] rad;
		logic [31:0] since;
		was = cur_mode;
		m = cur_mode;
		f = cur_flags;
		if (!hv_armed) begin
			hv_start = r.now_ms;
			hv_armed = 1'b1;
		end
		// recovery clears first, so misses in the same word win
		if (r.detector_recovered)
			det_failed = 1'b0;
		if (r.detector_misses >= MISS_LIMIT)
			det_failed = 1'b1;
		if (det_failed != det_failed_prev) begin
			if (det_failed) begin
				m = MODE_DTC;
				f = ST_DTC;
			end else begin
				m = MODE_NORMAL;
				f = ST_RESET;
				hv_start = r.now_ms;
				hv_armed = 1'b1;
			end
			det_failed_prev = det_failed;
		end
		rad = det_failed ? 32'd0 : {8'd0, r.dose_mrh_centi} * 32'd10;

		since = r.now_ms - hv_start;
		if (rad >= pcfg.overload_level && m != MODE_OVERLOAD && m != MODE_ACK_OL &&
			m != MODE_DTC) begin
			m = MODE_OVERLOAD;
			f = (f & ~(ST_ALARM | ST_OVERRUN | ST_RESET | ST_ACK | ST_HV)) | ST_OVERLOAD;
			ack_start = r.now_ms;
		end else if (rad >= pcfg.overrun_level && m != MODE_OVERRUN && m != MODE_OVERLOAD &&
			m != MODE_ACK_OL && m != MODE_ACK_OR && m != MODE_DTC) begin
			m = MODE_OVERRUN;
			f = (f & ~(ST_ALARM | ST_RESET | ST_ACK | ST_HV)) | ST_OVERRUN;
			ack_start = r.now_ms;
		end else if (rad >= pcfg.alarm_level && m != MODE_ALARM && m != MODE_ACK_AL &&
			m != MODE_OVERLOAD && m != MODE_ACK_OL && m != MODE_OVERRUN &&
			m != MODE_ACK_OR && m != MODE_DTC) begin
			m = MODE_ALARM;
			f = (f & ~(ST_RESET | ST_HV)) | ST_ALARM;
			ack_start = r.now_ms;
		end else if ((r.hv_decivolts < pcfg.hv_low_limit ||
			r.hv_decivolts > pcfg.hv_high_limit) && m == MODE_NORMAL && hv_armed &&
			since > {16'd0, pcfg.hv_holdoff_ms}) begin
			m = MODE_HV;
			f = (f & ~ST_RESET) | ST_HV;
			hv_armed = 1'b0;
		end

		// leaving HV fault needs the voltage strictly inside the window
		if (m == MODE_HV && r.hv_decivolts > pcfg.hv_low_limit &&
			r.hv_decivolts < pcfg.hv_high_limit) begin
			m = MODE_NORMAL;
			f = (f & ~ST_HV) | ST_RESET;
		end

		since = r.now_ms - ack_start;
		if ((m == MODE_ALARM || m == MODE_OVERRUN || m == MODE_OVERLOAD) &&
			(r.ack_btn || (pcfg.auto_mode && since > {12'd0, pcfg.auto_ack_ms}))) begin
			case (m)
				MODE_ALARM:   m = MODE_ACK_AL;
				MODE_OVERRUN: m = MODE_ACK_OR;
				default:      m = MODE_ACK_OL;
			endcase
			f = f | ST_ACK;
			ack_start = r.now_ms;
		end

		if (((m == MODE_ACK_OL && rad < pcfg.overload_level) ||
			(m == MODE_ACK_AL && rad < pcfg.alarm_level) ||
			(m == MODE_ACK_OR && rad < pcfg.overrun_level)) &&
			(r.rst_btn || pcfg.auto_mode)) begin
			m = MODE_NORMAL;
			f = (f & ~(ST_ACK | ST_OVERLOAD | ST_OVERRUN | ST_ALARM | ST_HV)) | ST_RESET;
		end

		cur_mode = m;
		cur_flags = f;
		if (m != was) begin
			case (m)
				MODE_ALARM, MODE_OVERRUN, MODE_OVERLOAD: ind_pat = IND_ACTIVE;
				MODE_ACK_AL, MODE_ACK_OR, MODE_ACK_OL:   ind_pat = IND_ACKED;
				MODE_HV, MODE_DTC:                       ind_pat = IND_FAULT;
				default:                                 ind_pat = IND_NORMAL;
			endcase
		end
		res.mode = m;
		res.status_bits = f;
		res.indicators = ind_pat;
		res.mode_changed = (m != was);
		return res;
	endfunction

	// driver: one evaluation word per handshake
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			tx_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				awaited_results.push_back(evaluate_reading(tx_item));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (tx_idle_on && $urandom_range(0, 7) == 0) begin
					tx_gap <= $urandom_range(0, 14);
					s_axis_tvalid <= 1'b0;
				end else if (reading_q.size() != 0) begin
					tx_item <= reading_q[0];
					s_axis_tdata <= {6'd0, reading_q[0].detector_recovered,
						reading_q[0].detector_misses, reading_q[0].rst_btn,
						reading_q[0].ack_btn, reading_q[0].hv_decivolts,
						reading_q[0].dose_mrh_centi, reading_q[0].now_ms};
					void'(reading_q.pop_front());
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : monitor
		result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_gap <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_results.size() == 0) begin
					$error("result word %h with no evaluation pending", m_axis_tdata);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					if (m_axis_tdata[3:0] !== want.mode) begin
						$error("mode: expected %0d, got %0d", want.mode, m_axis_tdata[3:0]);
						errors++;
					end
					if (m_axis_tdata[10:4] !== want.status_bits) begin
						$error("status_bits: expected %h, got %h", want.status_bits,
							m_axis_tdata[10:4]);
						errors++;
					end
					if (m_axis_tdata[15:11] !== want.indicators) begin
						$error("indicators: expected %h, got %h", want.indicators,
							m_axis_tdata[15:11]);
						errors++;
					end
					if (m_axis_tdata[16] !== want.mode_changed) begin
						$error("mode_changed: expected %0d, got %0d", want.mode_changed,
							m_axis_tdata[16]);
						errors++;
					end
				end
			end
			if (rx_hold_ack != rx_hold_req) begin
				rx_hold_ack <= rx_hold_req;
				rx_gap <= LONG_HOLD - 1;
				m_axis_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				m_axis_tready <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
				rx_gap <= $urandom_range(0, 14);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// leaves cfg_valid high; the caller drops it after the last word
	task automatic send_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] field,
		input int keep);
		logic [31:0] data;
		data = field;
		if ($urandom_range(0, 1) == 1)
			data = field | ($urandom() << keep);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_ALARM_LEVEL:    pcfg.alarm_level = data[26:0];
			REG_OVERRUN_LEVEL:  pcfg.overrun_level = data[26:0];
			REG_OVERLOAD_LEVEL: pcfg.overload_level = data[26:0];
			REG_HV_LOW_LIMIT:   pcfg.hv_low_limit = data[14:0];
			REG_HV_HIGH_LIMIT:  pcfg.hv_high_limit = data[14:0];
			REG_AUTO_MODE:      pcfg.auto_mode = data[0];
			REG_HV_HOLDOFF_MS:  pcfg.hv_holdoff_ms = data[15:0];
			REG_AUTO_ACK_MS:    pcfg.auto_ack_ms = data[19:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input cfg_t c);
		send_reg(REG_ALARM_LEVEL, {5'd0, c.alarm_level}, 27);
		send_reg(REG_OVERRUN_LEVEL, {5'd0, c.overrun_level}, 27);
		send_reg(REG_OVERLOAD_LEVEL, {5'd0, c.overload_level}, 27);
		send_reg(REG_HV_LOW_LIMIT, {17'd0, c.hv_low_limit}, 15);
		send_reg(REG_HV_HIGH_LIMIT, {17'd0, c.hv_high_limit}, 15);
		send_reg(REG_AUTO_MODE, {31'd0, c.auto_mode}, 1);
		send_reg(REG_HV_HOLDOFF_MS, {16'd0, c.hv_holdoff_ms}, 16);
		send_reg(REG_AUTO_ACK_MS, {12'd0, c.auto_ack_ms}, 20);
		send_reg(REG_SPARE, $urandom(), 32);
		cfg_valid <= 1'b0;
	endtask

	function automatic cfg_t pick_settings(input int flavor);
		cfg_t c;
		int unsigned lvl;
		c = '0;
		case (flavor)
			FLAVOR_ZERO: c.auto_mode = 1'b1;
			FLAVOR_MAX: begin
				c = '1;
				c.auto_mode = 1'b0;
			end
			FLAVOR_WILD: begin
				c.alarm_level = 27'($urandom());
				c.overrun_level = 27'($urandom());
				c.overload_level = 27'($urandom());
				c.hv_low_limit = 15'($urandom());
				c.hv_high_limit = 15'($urandom());
				c.auto_mode = 1'($urandom());
				c.hv_holdoff_ms = 16'($urandom_range(0, 2000));
				c.auto_ack_ms = 20'($urandom());
			end
			default: begin
				lvl = $urandom_range(0, 3000000);
				c.alarm_level = 27'(lvl);
				lvl = lvl + $urandom_range(0, 10000000);
				c.overrun_level = 27'(lvl);
				lvl = lvl + $urandom_range(0, 40000000);
				c.overload_level = 27'(lvl);
				lvl = $urandom_range(0, 12000);
				c.hv_low_limit = 15'(lvl);
				c.hv_high_limit = 15'(lvl + $urandom_range(0, 8000));
				c.auto_mode = 1'($urandom_range(0, 1));
				c.hv_holdoff_ms = 16'($urandom_range(0, 3000));
				c.auto_ack_ms = 20'($urandom_range(0, 4000));
			end
		endcase
		return c;
	endfunction

	// region picks which threshold the dose hovers around: 0 quiet, 1..3 the
	// alarm, overrun and overload levels, 4 anything
	function automatic item_t make_reading(input int region);
		item_t r;
		int    base;
		int    dose;
		int    hv;
		int    lo;
		int    hi;
		lo = int'(pcfg.hv_low_limit);
		hi = int'(pcfg.hv_high_limit);
		case ($urandom_range(0, 19))
			0:       cur_now = $urandom();
			1, 2:    cur_now = cur_now + $urandom_range(0, 32'h0020_0000);
			3, 4, 5: cur_now = cur_now + $urandom_range(0, 70000);
			default: cur_now = cur_now + $urandom_range(0, 300);
		endcase
		r.now_ms = cur_now;
		case (region)
			1:       base = int'(pcfg.alarm_level) / 10;
			2:       base = int'(pcfg.overrun_level) / 10;
			3:       base = int'(pcfg.overload_level) / 10;
			default: base = 0;
		endcase
		if (region >= 4)
			dose = int'($urandom_range(0, DOSE_MAX));
		else if (region == 0)
			dose = int'($urandom_range(0, 20));
		else if ($urandom_range(0, 3) == 0)
			dose = int'($urandom_range(0, base));
		else
			dose = base + int'($urandom_range(0, 4)) - 2;
		if (dose < 0)
			dose = 0;
		else if (dose > DOSE_MAX)
			dose = DOSE_MAX;
		r.dose_mrh_centi = 24'(dose);
		case ($urandom_range(0, 7))
			0:       hv = int'($urandom_range(0, HV_MAX));
			1:       hv = lo + int'($urandom_range(0, 2)) - 1;
			2:       hv = hi + int'($urandom_range(0, 2)) - 1;
			default: hv = int'($urandom_range(lo, hi));
		endcase
		if (hv < 0)
			hv = 0;
		else if (hv > HV_MAX)
			hv = HV_MAX;
		r.hv_decivolts = 15'(hv);
		r.ack_btn = ($urandom_range(0, 5) == 0);
		r.rst_btn = ($urandom_range(0, 5) == 0);
		case ($urandom_range(0, 39))
			0:       r.detector_misses = 8'($urandom());
			1:       r.detector_misses = MISS_LIMIT;
			2, 3, 4: r.detector_misses = 8'($urandom_range(1, 2));
			default: r.detector_misses = '0;
		endcase
		r.detector_recovered = ($urandom_range(0, 7) == 0);
		return r;
	endfunction

	task automatic queue_random_readings(input int count);
		int region;
		int run;
		region = 0;
		run = 0;
		for (int i = 0; i < count; i++) begin
			if (run == 0) begin
				region = $urandom_range(0, 4);
				run = $urandom_range(1, 10);
			end
			reading_q.push_back(make_reading(region));
			run--;
		end
	endtask

	task automatic push_reading(input logic [31:0] t, input logic [23:0] dose,
		input logic [14:0] hv, input logic ack, input logic rst, input logic [7:0] misses,
		input logic rec);
		item_t r;
		r.now_ms = t;
		r.dose_mrh_centi = dose;
		r.hv_decivolts = hv;
		r.ack_btn = ack;
		r.rst_btn = rst;
		r.detector_misses = misses;
		r.detector_recovered = rec;
		reading_q.push_back(r);
	endtask

	task automatic wait_all_results();
		@(posedge clk);
		while (reading_q.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		cfg_t bench;
		int   flavor;
		pcfg = '0;
		pcfg.hv_high_limit = 15'd20000;
		pcfg.hv_holdoff_ms = 16'd5000;
		pcfg.auto_ack_ms = 20'd60000;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		bench = '0;
		bench.alarm_level = 27'd1000;
		bench.overrun_level = 27'd5000;
		bench.overload_level = 27'd20000;
		bench.hv_low_limit = 15'd3000;
		bench.hv_high_limit = 15'd9000;
		bench.hv_holdoff_ms = 16'd100;
		bench.auto_ack_ms = 20'd500;
		apply_config(bench);

		// HV window and holdoff
		push_reading(32'd1000, 24'd0, 15'd5000, 1'b0, 1'b0, 8'd0, 1'b0);
		push_reading(32'd1050, 24'd0, 15'd2000, 1'b0, 1'b0, 8'd0, 1'b0);
		push_reading(32'd1101, 24'd0, 15'd2000, 1'b0, 1'b0, 8'd0, 1'b0);
		push_reading(32'd1102, 24'd0, 15'd3000, 1'b0, 1'b0, 8'd0, 1'b0);
		push_reading(32'd1103, 24'd0, 15'd5000, 1'b0, 1'b0, 8'd0, 1'b0);
		push_reading(32'd1150, 24'd0, 15'd9001, 1'b0, 1'b0, 8'd0, 1'b0);
		push_reading(32'd1300, 24'd0, 15'd9000, 1'b0, 1'b0, 8'd0, 1'b0);
		// alarm, ack, reset refused while still high, then accepted
		push_reading(32'd1310, 24'd99, 15'd5000, 1'b0, 1'b0, 8'd0, 1'b0);
		push_reading(32'd1320, 24'd100, 15'd5000, 1'b0, 1'b0, 8'd0, 1'b0);
		push_reading(32'd1330, 24'd100, 15'd5000, 1'b1, 1'b0, 8'd0, 1'b0);
		push_reading(32'd1340, 24'd100, 15'd5000, 1'b0, 1'b1, 8'd0, 1'b0);
		push_reading(32'd1350, 24'd99, 15'd5000, 1'b0, 1'b1, 8'd0, 1'b0);
		// overload, acked, reset below overload, then overrun
		push_reading(32'd1360, 24'd2000, 15'd5000, 1'b0, 1'b0, 8'd0, 1'b0);
		push_reading(32'd1370, 24'd500, 15'd5000, 1'b1, 1'b0, 8'd0, 1'b0);
		push_reading(32'd1380, 24'd500, 15'd5000, 1'b0, 1'b1, 8'd0, 1'b0);
		push_reading(32'd1390, 24'd500, 15'd5000, 1'b0, 1'b0, 8'd0, 1'b0);
		// detector failure, recovery with misses in the same word, clean recovery
		push_reading(32'd1400, 24'd500, 15'd5000, 1'b0, 1'b0, MISS_LIMIT, 1'b0);
		push_reading(32'd1410, 24'd2000, 15'd5000, 1'b0, 1'b0, 8'hFF, 1'b1);
		push_reading(32'd1420, 24'd0, 15'd5000, 1'b0, 1'b0, 8'd2, 1'b1);
		// field extremes and time wrap
		push_reading(32'hFFFF_FFFF, 24'hFF_FFFF, 15'h7FFF, 1'b1, 1'b1, 8'hFF, 1'b1);
		push_reading(32'd0, 24'd0, 15'd0, 1'b1, 1'b1, 8'd0, 1'b0);
		push_reading(32'h8000_0000, 24'h80_0000, 15'h4000, 1'b0, 1'b0, 8'h80, 1'b1);
		wait_all_results();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 1)
				flavor = FLAVOR_ZERO;
			else if (ph == 4)
				flavor = FLAVOR_MAX;
			else if (ph == 3 || ph == 6)
				flavor = FLAVOR_WILD;
			else
				flavor = FLAVOR_ORDERED;
			apply_config(pick_settings(flavor));
			if (ph == WRAP_PHASE)
				cur_now = 32'hFFFF_8000;
			if (ph == PRESSURE_PHASE) begin
				// sink stalls long while the source keeps offering words
				tx_idle_on = 1'b0;
				rx_hold_req = rx_hold_req + 1;
			end
			if (ph == PHASES - 1) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end
			queue_random_readings(PHASE_ITEMS / 2);
			wait_all_results();
			queue_random_readings(PHASE_ITEMS / 2);
			wait_all_results();
			if (ph == PRESSURE_PHASE)
				tx_idle_on = 1'b1;
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$error("%0d result words never arrived", awaited_results.size());
			errors++;
		end
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
